[sv/esd_pkg.sv]
// Shared types, constants and helper functions of the escape sequence decoder.
package esd_pkg;

    localparam int CHAR_W = 8;
    localparam int ACC_W = 6;
    localparam int MODE_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Decode modes; codes above MODE_OCT2 behave as MODE_NORMAL.
    localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CARET = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ESC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OCT1 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OCT2 = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CARET_OFFSET = 8'h40;
    localparam logic [CHAR_W-1:0] STOP_RESET = 8'h20;
    localparam logic [4:0] OCTAL_PREFIX = 5'b00110;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic has_char;
        logic string_done;
        logic hit_stop;
    } t_result;

    // One input byte's worth of results: one or two.
    typedef struct packed {
        t_result first;
        t_result second;
        logic two;
    } t_entry;

    function automatic logic is_octal(input logic [CHAR_W-1:0] c);
        return c[7:3] == OCTAL_PREFIX;
    endfunction

    function automatic logic [CHAR_W-1:0] escape_map(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] m;
        unique case (c)
            8'h6E: m = 8'h0A;
            8'h72: m = 8'h0D;
            8'h74: m = 8'h09;
            8'h62: m = 8'h08;
            8'h66: m = 8'h0C;
            default: m = c;
        endcase
        return m;
    endfunction

endpackage

[sv/esd_if.sv]
// Handshake channels of the escape sequence decoder: input bytes, results, configuration.
interface esd_char_if;
    logic valid;
    logic ready;
    logic [esd_pkg::CHAR_W-1:0] in_char;
    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface esd_res_if;
    logic valid;
    logic ready;
    logic [esd_pkg::CHAR_W-1:0] out_char;
    logic has_char;
    logic string_done;
    logic hit_stop;
    logic last_of_item;
    modport source (output valid, output out_char, output has_char, output string_done,
                    output hit_stop, output last_of_item, input ready);
    modport sink (input valid, input out_char, input has_char, input string_done,
                  input hit_stop, input last_of_item, output ready);
endinterface

interface esd_cfg_if;
    logic valid;
    logic ready;
    logic [esd_pkg::CHAR_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/esd_front.sv]
// Front end: accepts raw bytes, tracks the decode mode and queues the results each byte causes.
module esd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    esd_char_if.sink                     i_char_in,
    input  logic [esd_pkg::CHAR_W-1:0]   i_stop_char,
    input  logic                         i_full,
    output logic                         o_push,
    output esd_pkg::t_entry              o_entry
);

    typedef struct packed {
        logic emit;
        esd_pkg::t_result res;
        logic [esd_pkg::MODE_W-1:0] mode;
    } t_norm;

    logic [esd_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [esd_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [esd_pkg::CHAR_W-1:0] c;
    logic                       accept;
    logic                       emit;
    esd_pkg::t_entry            ent;
    t_norm                      nb;

    // Handling of a byte in normal mode.
    function automatic t_norm normal_byte(input logic [esd_pkg::CHAR_W-1:0] ch,
                                          input logic [esd_pkg::CHAR_W-1:0] stop);
        t_norm r;
        r = '0;
        r.mode = esd_pkg::MODE_NORMAL;
        if (ch == esd_pkg::CHAR_NUL) begin
            r.emit = 1'b1;
            r.res.string_done = 1'b1;
        end else if (ch == stop) begin
            r.emit = 1'b1;
            r.res.string_done = 1'b1;
            r.res.hit_stop = 1'b1;
        end else if (ch == esd_pkg::CHAR_CARET) begin
            r.mode = esd_pkg::MODE_CARET;
        end else if (ch == esd_pkg::CHAR_BSLASH) begin
            r.mode = esd_pkg::MODE_ESC;
        end else begin
            r.emit = 1'b1;
            r.res.out_char = ch;
            r.res.has_char = 1'b1;
        end
        return r;
    endfunction

    assign c = i_char_in.in_char;
    assign i_char_in.ready = !i_full;
    assign accept = i_char_in.valid && !i_full;

    always_comb begin
        nb = normal_byte(c, i_stop_char);
        n_mode = r_mode;
        n_acc = r_acc;
        emit = 1'b0;
        ent = '0;
        unique case (r_mode)
            esd_pkg::MODE_CARET: begin
                n_mode = esd_pkg::MODE_NORMAL;
                emit = 1'b1;
                ent.first.has_char = 1'b1;
                if (c == esd_pkg::CHAR_NUL) begin
                    ent.first.out_char = esd_pkg::CHAR_CARET;
                    ent.second.string_done = 1'b1;
                    ent.two = 1'b1;
                end else begin
                    ent.first.out_char = c - esd_pkg::CARET_OFFSET;
                end
            end
            esd_pkg::MODE_ESC: begin
                n_mode = esd_pkg::MODE_NORMAL;
                if (c == esd_pkg::CHAR_NUL) begin
                    emit = 1'b1;
                    ent.first.string_done = 1'b1;
                end else if (esd_pkg::is_octal(c)) begin
                    n_acc = {3'b000, c[2:0]};
                    n_mode = esd_pkg::MODE_OCT1;
                end else begin
                    emit = 1'b1;
                    ent.first.out_char = esd_pkg::escape_map(c);
                    ent.first.has_char = 1'b1;
                end
            end
            esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2: begin
                if (esd_pkg::is_octal(c) && r_mode == esd_pkg::MODE_OCT1) begin
                    n_acc = {r_acc[2:0], c[2:0]};
                    n_mode = esd_pkg::MODE_OCT2;
                end else if (esd_pkg::is_octal(c)) begin
                    n_mode = esd_pkg::MODE_NORMAL;
                    emit = 1'b1;
                    ent.first.out_char = {r_acc[4:0], c[2:0]};
                    ent.first.has_char = 1'b1;
                end else begin
                    // The pending code goes out first, then the byte is decoded normally.
                    n_mode = nb.mode;
                    emit = 1'b1;
                    ent.first.out_char = {2'b00, r_acc};
                    ent.first.has_char = 1'b1;
                    ent.second = nb.res;
                    ent.two = nb.emit;
                end
            end
            default: begin
                n_mode = nb.mode;
                emit = nb.emit;
                ent.first = nb.res;
            end
        endcase
    end

    assign o_push = accept && emit;
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= esd_pkg::MODE_NORMAL;
            r_acc <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc <= n_acc;
        end
    end

endmodule

[sv/esd_queue.sv]
// Short queue of decoded entries between the front end and the output stage.
module esd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output esd_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);

    esd_pkg::t_entry                r_mem [esd_pkg::QUEUE_DEPTH];
    logic [esd_pkg::QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [esd_pkg::QUEUE_AW:0]     r_count, n_count;
    logic                           do_push, do_pop;

    assign o_full = r_count == (esd_pkg::QUEUE_AW + 1)'(esd_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (esd_pkg::QUEUE_AW + 1)'(esd_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != (esd_pkg::QUEUE_AW + 1)'(esd_pkg::QUEUE_DEPTH))
        |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

[sv/esd_back.sv]
// Output stage: takes queued entries and presents their one or two results in order.
module esd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  esd_pkg::t_entry i_entry,
    output logic            o_pop,
    esd_res_if.source       o_res_out
);

    logic            r_valid;
    logic            r_second;
    esd_pkg::t_entry r_ent;
    esd_pkg::t_result cur;
    logic            last;
    logic            xfer;

    assign cur = r_second ? r_ent.second : r_ent.first;
    assign last = r_second || !r_ent.two;
    assign xfer = r_valid && o_res_out.ready;
    assign o_pop = !i_empty && (!r_valid || (xfer && last));

    assign o_res_out.valid = r_valid;
    assign o_res_out.out_char = cur.out_char;
    assign o_res_out.has_char = cur.has_char;
    assign o_res_out.string_done = cur.string_done;
    assign o_res_out.hit_stop = cur.hit_stop;
    assign o_res_out.last_of_item = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_second <= 1'b0;
        end else if (xfer) begin
            // A two-result entry stays for a second transfer.
            r_valid <= !last;
            r_second <= !last;
        end
    end

    a_second_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && r_ent.two))
        else $error("second result shown for a single-result entry");

    a_first_then_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && !r_second && r_ent.two) |=> (r_valid && r_second))
        else $error("second result of an entry was dropped");

endmodule

[sv/escape_sequence_decoder.sv]
// Top level of the escape sequence decoder: configuration register, front end, queue, output stage.
//
// Usage: raw bytes enter on i_char_in (valid/ready); each accepted byte yields zero, one or
// two results on o_res_out (valid/ready). Bytes that only change the mode ('^', a backslash,
// a first or second octal digit) produce nothing. The last result of a byte carries
// last_of_item. string_done marks the end of a string, with hit_stop telling a stop byte
// from end of text (NUL).
// i_cfg writes stop_char; it is always ready and should be written only while idle.
// The result of a byte is written into the queue and then into the output register before
// it is shown on o_res_out; it can wait in the queue while earlier results are still held.
// Throughput: one byte per cycle while each byte yields at most one result and the receiver
// is ready; a byte with two results holds the output register for two transfers, and the
// four-entry queue absorbs such bursts. i_char_in.ready drops only when the queue is full.
// Reset (synchronous, active low) returns to normal mode, clears the octal value,
// empties the queue and sets stop_char to a space.
// When the receiver stalls, the current result holds and the queue fills; the input
// side keeps accepting until the queue is full.
module escape_sequence_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esd_char_if.sink  i_char_in,
    esd_cfg_if.sink   i_cfg,
    esd_res_if.source o_res_out
);

    logic [esd_pkg::CHAR_W-1:0] r_stop_char;
    logic                       push, pop, full, empty;
    esd_pkg::t_entry            push_entry, head_entry;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_char <= esd_pkg::STOP_RESET;
        end else if (i_cfg.valid) begin
            r_stop_char <= i_cfg.data;
        end
    end

    esd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_in   (i_char_in),
        .i_stop_char (r_stop_char),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    esd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    esd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_res_out (o_res_out)
    );

endmodule
